[rtl/core/color_keyed_bitmap_region_blit_assert.svh]
// assertion helpers shared by the blit core
`ifndef COLOR_KEYED_BITMAP_REGION_BLIT_ASSERT_SVH
`define COLOR_KEYED_BITMAP_REGION_BLIT_ASSERT_SVH

// checked at every clock edge outside reset
`define CKBB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked in the cycle after the trigger
`define CKBB_ASSERT_NEXT(lbl, trig, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (prop)) \
    else $error(msg);

`endif

[rtl/core/ckbb_pkg.sv]
`default_nettype none

package ckbb_pkg;

  localparam int SRC_W      = 18;
  localparam int DST_W      = 16;
  localparam int PIX_W      = 8;
  localparam int DX_W       = 9;
  localparam int DY_W       = 8;
  localparam int COL_W      = 10;
  localparam int ROW_W      = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEST_X   = 3'd0,
    CFG_DEST_Y   = 3'd1,
    CFG_REGION_X = 3'd2,
    CFG_REGION_Y = 3'd3,
    CFG_REGION_W = 3'd4,
    CFG_REGION_H = 3'd5,
    CFG_IMAGE_W  = 3'd6,
    CFG_IMAGE_H  = 3'd7
  } cfg_idx_e;

  typedef enum logic {
    REQ_START = 1'b0,
    REQ_PIXEL = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    ITEM_START = 2'd0,
    ITEM_PIXEL = 2'd1,
    ITEM_ERROR = 2'd2
  } item_e;

  typedef struct packed {
    logic [DX_W-1:0]  dest_x;
    logic [DY_W-1:0]  dest_y;
    logic [COL_W-1:0] region_x;
    logic [ROW_W-1:0] region_y;
    logic [COL_W-1:0] region_w;
    logic [ROW_W-1:0] region_h;
    logic [COL_W-1:0] image_w;
    logic [ROW_W-1:0] image_h;
  } cfg_t;

  typedef struct packed {
    item_e            kind;
    logic [PIX_W-1:0] pixel;
    logic             key_on;
    logic [PIX_W-1:0] key_value;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] column;
    logic [SRC_W-1:0] nxt;
    logic             last;
  } item_t;

endpackage

`default_nettype wire

[rtl/core/ckbb_front.sv]
`default_nettype none

module ckbb_front #(
  parameter int HEADER_BYTES = 1078
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire ckbb_pkg::cfg_t            cfg_i,
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire logic                      req_type_i,
  input  wire logic [ckbb_pkg::PIX_W-1:0] src_pixel_i,
  input  wire logic                      key_enable_i,
  input  wire logic [ckbb_pkg::PIX_W-1:0] key_color_i,
  output logic                           q_push_o,
  output ckbb_pkg::item_t                q_item_o,
  input  wire logic                      q_full_i
);
  import ckbb_pkg::*;

  logic             busy_q, busy_d;
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [SRC_W-1:0] src_q, src_d;
  logic             key_on_q, key_on_d;
  logic [PIX_W-1:0] key_val_q, key_val_d;

  logic             accept;
  logic [SRC_W-1:0] rows_up;
  logic [SRC_W-1:0] first_src;
  logic [SRC_W-1:0] row_step;
  logic             col_end;
  logic             row_end;
  logic             zero_size;
  item_t            item;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign q_push_o   = accept;
  assign q_item_o   = item;

  // bottom-up bitmap: region top row sits image_h-1-region_y rows above the data start
  assign rows_up   = SRC_W'(cfg_i.image_h) - SRC_W'(1) - SRC_W'(cfg_i.region_y);
  assign first_src = SRC_W'(HEADER_BYTES) + SRC_W'(SRC_W'(cfg_i.image_w) * rows_up)
                   + SRC_W'(cfg_i.region_x);
  // back to the region's left edge, one bitmap row down (image_w nearer the data start)
  assign row_step  = SRC_W'(1) - SRC_W'(cfg_i.region_w) - SRC_W'(cfg_i.image_w);

  assign col_end   = ((COL_W+1)'(col_q) + (COL_W+1)'(1)) >= (COL_W+1)'(cfg_i.region_w);
  assign row_end   = ((ROW_W+1)'(row_q) + (ROW_W+1)'(1)) >= (ROW_W+1)'(cfg_i.region_h);
  assign zero_size = (cfg_i.region_w == '0) || (cfg_i.region_h == '0);

  always_comb begin
    busy_d    = busy_q;
    col_d     = col_q;
    row_d     = row_q;
    src_d     = src_q;
    key_on_d  = key_on_q;
    key_val_d = key_val_q;

    item           = '0;
    item.kind      = ITEM_ERROR;
    item.pixel     = src_pixel_i;
    item.key_on    = key_on_q;
    item.key_value = key_val_q;
    item.row       = row_q;
    item.column    = col_q;

    if (req_type_i == REQ_START) begin
      item.kind = ITEM_START;
      key_on_d  = key_enable_i;
      key_val_d = key_color_i;
      col_d     = '0;
      row_d     = '0;
      if (zero_size) begin
        busy_d    = 1'b0;
        src_d     = '0;
        item.last = 1'b1;
        item.nxt  = '0;
      end else begin
        busy_d   = 1'b1;
        src_d    = first_src;
        item.nxt = first_src;
      end
    end else if (!busy_q) begin
      item.kind = ITEM_ERROR;
    end else begin
      item.kind = ITEM_PIXEL;
      if (col_end) begin
        col_d = '0;
        if (row_end) begin
          row_d     = '0;
          busy_d    = 1'b0;
          src_d     = '0;
          item.last = 1'b1;
        end else begin
          row_d = row_q + ROW_W'(1);
          src_d = src_q + row_step;
        end
      end else begin
        col_d = col_q + COL_W'(1);
        src_d = src_q + SRC_W'(1);
      end
      item.nxt = item.last ? '0 : src_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      col_q     <= '0;
      row_q     <= '0;
      src_q     <= '0;
      key_on_q  <= 1'b0;
      key_val_q <= '0;
    end else if (accept) begin
      busy_q    <= busy_d;
      col_q     <= col_d;
      row_q     <= row_d;
      src_q     <= src_d;
      key_on_q  <= key_on_d;
      key_val_q <= key_val_d;
    end
  end

endmodule

`default_nettype wire

[rtl/core/ckbb_queue.sv]
`default_nettype none

module ckbb_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire ckbb_pkg::item_t item_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output logic                 valid_o,
  output ckbb_pkg::item_t      item_o
);
  import ckbb_pkg::*;

  item_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q;
  logic [QPTR_W-1:0] rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
        2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  `include "color_keyed_bitmap_region_blit_assert.svh"

  `CKBB_ASSERT(a_cnt_bound, cnt_q <= QCNT_W'(QUEUE_DEPTH), "queue count beyond depth")
  `CKBB_ASSERT(a_no_overflow, !(push_i && full_o), "word pushed into full queue")
  `CKBB_ASSERT(a_no_underflow, !(pop_i && !valid_o), "word popped from empty queue")
  `CKBB_ASSERT_NEXT(a_cnt_grows, push_i && !pop_i, cnt_q == $past(cnt_q) + QCNT_W'(1),
    "queue count did not follow a lone push")

endmodule

`default_nettype wire

[rtl/core/ckbb_back.sv]
`default_nettype none

module ckbb_back #(
  parameter int LINE_PITCH  = 320,
  parameter int FRAME_BYTES = 64000
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire ckbb_pkg::cfg_t             cfg_i,
  input  wire logic                       q_valid_i,
  input  wire ckbb_pkg::item_t            q_item_i,
  output logic                            q_pop_o,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic [ckbb_pkg::DST_W-1:0]      dst_offset_o,
  output logic [ckbb_pkg::PIX_W-1:0]      pixel_out_o,
  output logic                            write_en_o,
  output logic [ckbb_pkg::SRC_W-1:0]      next_src_offset_o,
  output logic                            last_o,
  output logic                            out_of_frame_o,
  output logic                            protocol_error_o
);
  import ckbb_pkg::*;

  localparam int DMAX   = ((1 << DY_W) - 1 + (1 << ROW_W) - 1) * LINE_PITCH
                        + (1 << DX_W) - 1 + (1 << COL_W) - 1;
  localparam int DMAX_W = $clog2(DMAX + 1);
  localparam int FRM_W  = $clog2(FRAME_BYTES + 1);
  localparam int DLIN_W = (DMAX_W > FRM_W) ? DMAX_W : FRM_W;

  logic [DY_W:0]       line;
  logic [DLIN_W-1:0]   dlin;
  logic                oof;
  logic                load;

  logic                valid_q;
  logic [DST_W-1:0]    dst_q, dst_d;
  logic [PIX_W-1:0]    pix_q, pix_d;
  logic                we_q, we_d;
  logic [SRC_W-1:0]    nxt_q, nxt_d;
  logic                last_q, last_d;
  logic                oof_q, oof_d;
  logic                perr_q, perr_d;

  assign load    = q_valid_i && (!valid_q || !out_stall_i);
  assign q_pop_o = load;

  // linear frame offset: lines run on, so a wide region wraps onto the next line
  assign line = (DY_W+1)'(cfg_i.dest_y) + (DY_W+1)'(q_item_i.row);
  assign dlin = DLIN_W'(DLIN_W'(line) * DLIN_W'(LINE_PITCH))
              + DLIN_W'(cfg_i.dest_x) + DLIN_W'(q_item_i.column);
  assign oof  = dlin >= DLIN_W'(FRAME_BYTES);

  always_comb begin
    dst_d  = '0;
    pix_d  = '0;
    we_d   = 1'b0;
    nxt_d  = '0;
    last_d = 1'b0;
    oof_d  = 1'b0;
    perr_d = 1'b0;
    unique case (q_item_i.kind)
      ITEM_START: begin
        nxt_d  = q_item_i.nxt;
        last_d = q_item_i.last;
      end
      ITEM_PIXEL: begin
        pix_d  = q_item_i.pixel;
        nxt_d  = q_item_i.nxt;
        last_d = q_item_i.last;
        if (oof) begin
          oof_d = 1'b1;
        end else begin
          dst_d = DST_W'(dlin);
          we_d  = !(q_item_i.key_on && (q_item_i.pixel == q_item_i.key_value));
        end
      end
      ITEM_ERROR: begin
        perr_d = 1'b1;
      end
      default: begin
        perr_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      dst_q  <= dst_d;
      pix_q  <= pix_d;
      we_q   <= we_d;
      nxt_q  <= nxt_d;
      last_q <= last_d;
      oof_q  <= oof_d;
      perr_q <= perr_d;
    end
  end

  assign out_valid_o       = valid_q;
  assign dst_offset_o      = dst_q;
  assign pixel_out_o       = pix_q;
  assign write_en_o        = we_q;
  assign next_src_offset_o = nxt_q;
  assign last_o            = last_q;
  assign out_of_frame_o    = oof_q;
  assign protocol_error_o  = perr_q;

  `include "color_keyed_bitmap_region_blit_assert.svh"

  `CKBB_ASSERT(a_oof_no_write, !(valid_q && we_q && oof_q), "write enabled beyond frame")
  `CKBB_ASSERT(a_err_quiet, !(valid_q && perr_q && (we_q || last_q || nxt_q != '0)),
    "protocol error word carries pixel results")
  `CKBB_ASSERT(a_last_no_fetch, !(valid_q && last_q && nxt_q != '0),
    "final word asks for another fetch")

endmodule

`default_nettype wire

[rtl/core/color_keyed_bitmap_region_blit.sv]
// path: an accepted item is written into the queue, then popped into the offset
//   and key stage register that drives the result word; an output stall can hold it
// throughput: one item per cycle when unstalled, set by the front row/column update
// reset: asynchronous active low; clears the blit state, the queue and output valid,
//   and loads the region registers with their defaults; no clearing pass
`default_nettype none

module color_keyed_bitmap_region_blit #(
  parameter int LINE_PITCH   = 320,
  parameter int HEADER_BYTES = 1078,
  parameter int FRAME_BYTES  = 64000
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [ckbb_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [ckbb_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic                            req_type_i,
  input  wire logic [ckbb_pkg::PIX_W-1:0]      src_pixel_i,
  input  wire logic                            key_enable_i,
  input  wire logic [ckbb_pkg::PIX_W-1:0]      key_color_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic [ckbb_pkg::DST_W-1:0]           dst_offset_o,
  output logic [ckbb_pkg::PIX_W-1:0]           pixel_out_o,
  output logic                                 write_en_o,
  output logic [ckbb_pkg::SRC_W-1:0]           next_src_offset_o,
  output logic                                 last_o,
  output logic                                 out_of_frame_o,
  output logic                                 protocol_error_o
);
  import ckbb_pkg::*;

  cfg_t  cfg_q;
  logic  q_push;
  logic  q_full;
  logic  q_pop;
  logic  q_valid;
  item_t q_item_in;
  item_t q_item_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dest_x   <= '0;
      cfg_q.dest_y   <= '0;
      cfg_q.region_x <= '0;
      cfg_q.region_y <= '0;
      cfg_q.region_w <= '0;
      cfg_q.region_h <= '0;
      cfg_q.image_w  <= COL_W'(1);
      cfg_q.image_h  <= ROW_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_DEST_X:   cfg_q.dest_x   <= cfg_data_i[DX_W-1:0];
        CFG_DEST_Y:   cfg_q.dest_y   <= cfg_data_i[DY_W-1:0];
        CFG_REGION_X: cfg_q.region_x <= cfg_data_i[COL_W-1:0];
        CFG_REGION_Y: cfg_q.region_y <= cfg_data_i[ROW_W-1:0];
        CFG_REGION_W: cfg_q.region_w <= cfg_data_i[COL_W-1:0];
        CFG_REGION_H: cfg_q.region_h <= cfg_data_i[ROW_W-1:0];
        CFG_IMAGE_W:  cfg_q.image_w  <= cfg_data_i[COL_W-1:0];
        CFG_IMAGE_H:  cfg_q.image_h  <= cfg_data_i[ROW_W-1:0];
        default:      cfg_q          <= cfg_q;
      endcase
    end
  end

  ckbb_front #(
    .HEADER_BYTES (HEADER_BYTES)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .req_type_i   (req_type_i),
    .src_pixel_i  (src_pixel_i),
    .key_enable_i (key_enable_i),
    .key_color_i  (key_color_i),
    .q_push_o     (q_push),
    .q_item_o     (q_item_in),
    .q_full_i     (q_full)
  );

  ckbb_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_item_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (q_item_out)
  );

  ckbb_back #(
    .LINE_PITCH  (LINE_PITCH),
    .FRAME_BYTES (FRAME_BYTES)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg_q),
    .q_valid_i         (q_valid),
    .q_item_i          (q_item_out),
    .q_pop_o           (q_pop),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .dst_offset_o      (dst_offset_o),
    .pixel_out_o       (pixel_out_o),
    .write_en_o        (write_en_o),
    .next_src_offset_o (next_src_offset_o),
    .last_o            (last_o),
    .out_of_frame_o    (out_of_frame_o),
    .protocol_error_o  (protocol_error_o)
  );

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ckbb_pkg::*;

  localparam int LINE_PITCH   = 320;
  localparam int HEADER_BYTES = 1078;
  localparam int FRAME_BYTES  = 64000;
  localparam int CYCLE_LIMIT  = 1000000;

  typedef struct packed {
    logic [DST_W-1:0] dst_offset;
    logic [PIX_W-1:0] pixel;
    logic             write_en;
    logic [SRC_W-1:0] next_src;
    logic             last;
    logic             off_frame;
    logic             proto_err;
  } blit_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic req_type_i = 1'b0;
  logic [PIX_W-1:0] src_pixel_i = '0;
  logic key_enable_i = 1'b0;
  logic [PIX_W-1:0] key_color_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [DST_W-1:0] dst_offset_o;
  logic [PIX_W-1:0] pixel_out_o;
  logic write_en_o;
  logic [SRC_W-1:0] next_src_offset_o;
  logic last_o;
  logic out_of_frame_o;
  logic protocol_error_o;

  color_keyed_bitmap_region_blit #(
    .LINE_PITCH  (LINE_PITCH),
    .HEADER_BYTES(HEADER_BYTES),
    .FRAME_BYTES (FRAME_BYTES)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .req_type_i       (req_type_i),
    .src_pixel_i      (src_pixel_i),
    .key_enable_i     (key_enable_i),
    .key_color_i      (key_color_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .dst_offset_o     (dst_offset_o),
    .pixel_out_o      (pixel_out_o),
    .write_en_o       (write_en_o),
    .next_src_offset_o(next_src_offset_o),
    .last_o           (last_o),
    .out_of_frame_o   (out_of_frame_o),
    .protocol_error_o (protocol_error_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // shadow of the region registers and the blit walk
  cfg_t region;
  logic run_busy = 1'b0;
  logic [COL_W-1:0] col_cnt = '0;
  logic [ROW_W-1:0] row_cnt = '0;
  logic [SRC_W-1:0] src_ptr = '0;
  logic [PIX_W-1:0] key_val = '0;
  logic key_en = 1'b0;

  blit_word_t owed_words[$];
  int unsigned words_sent = 0;
  int unsigned bad_words = 0;
  int unsigned cycles = 0;
  int unsigned in_gap_pct = 15;
  int unsigned out_gap_pct = 15;
  int unsigned stall_left = 0;

  function automatic blit_word_t blit_advance(req_e kind, logic [PIX_W-1:0] pix,
                                              logic ken, logic [PIX_W-1:0] kcol);
    blit_word_t w;
    int unsigned rows;
    int unsigned d;
    w = '0;
    if (kind == REQ_START) begin
      key_en = ken;
      key_val = kcol;
      col_cnt = '0;
      row_cnt = '0;
      if (region.region_w == 0 || region.region_h == 0) begin
        run_busy = 1'b0;
        src_ptr = '0;
        w.last = 1'b1;
      end else begin
        // rows above the region wrap when region_y is image_h or more
        rows = 32'(region.image_h) - 1 - 32'(region.region_y);
        src_ptr = SRC_W'(HEADER_BYTES + 32'(region.image_w) * rows
                         + 32'(region.region_x));
        run_busy = 1'b1;
        w.next_src = src_ptr;
      end
    end else if (!run_busy) begin
      w.proto_err = 1'b1;
    end else begin
      d = 32'(region.dest_x) + LINE_PITCH * (32'(region.dest_y) + 32'(row_cnt))
          + 32'(col_cnt);
      w.pixel = pix;
      if (d >= FRAME_BYTES) begin
        w.off_frame = 1'b1;
      end else begin
        w.dst_offset = d[DST_W-1:0];
        w.write_en = !(key_en && pix == key_val);
      end
      if (32'(col_cnt) + 1 >= 32'(region.region_w)) begin
        col_cnt = '0;
        // step back to the start of the region on the image row below (image_w lower in the file)
        src_ptr = SRC_W'(32'(src_ptr) + 1 - 32'(region.region_w) - 32'(region.image_w));
        if (32'(row_cnt) + 1 >= 32'(region.region_h)) begin
          row_cnt = '0;
          run_busy = 1'b0;
          src_ptr = '0;
          w.last = 1'b1;
        end else begin
          row_cnt = row_cnt + 1'b1;
        end
      end else begin
        col_cnt = col_cnt + 1'b1;
        src_ptr = src_ptr + 1'b1;
      end
      if (!w.last) begin
        w.next_src = src_ptr;
      end
    end
    return w;
  endfunction

  // output side stall bursts
  always @(negedge clk_i) begin
    if (out_gap_pct == 0) begin
      out_stall_i = 1'b0;
      stall_left = 0;
    end else if (stall_left != 0) begin
      out_stall_i = 1'b1;
      stall_left = stall_left - 1;
    end else if ($urandom_range(99) < out_gap_pct) begin
      out_stall_i = 1'b1;
      stall_left = $urandom_range(18, 1) - 1;
    end else begin
      out_stall_i = 1'b0;
    end
  end

  always @(posedge clk_i) begin
    blit_word_t got;
    blit_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{dst_offset_o, pixel_out_o, write_en_o, next_src_offset_o,
              last_o, out_of_frame_o, protocol_error_o};
      if (owed_words.size() == 0) begin
        if (bad_words < 10) begin
          $display("cycle %0d: unexpected word dst=%h pix=%h we=%b nxt=%h last=%b oof=%b err=%b",
                   cycles, got.dst_offset, got.pixel, got.write_en, got.next_src,
                   got.last, got.off_frame, got.proto_err);
        end
        bad_words++;
      end else begin
        want = owed_words.pop_front();
        if (got.dst_offset !== want.dst_offset || got.pixel !== want.pixel ||
            got.write_en !== want.write_en || got.next_src !== want.next_src ||
            got.last !== want.last || got.off_frame !== want.off_frame ||
            got.proto_err !== want.proto_err) begin
          if (bad_words < 10) begin
            $display("cycle %0d: want dst=%h pix=%h we=%b nxt=%h last=%b oof=%b err=%b",
                     cycles, want.dst_offset, want.pixel, want.write_en, want.next_src,
                     want.last, want.off_frame, want.proto_err);
            $display("cycle %0d: got  dst=%h pix=%h we=%b nxt=%h last=%b oof=%b err=%b",
                     cycles, got.dst_offset, got.pixel, got.write_en, got.next_src,
                     got.last, got.off_frame, got.proto_err);
          end
          bad_words++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // entered and left just after a falling edge; valid stays up for the next word
  task automatic send_word(req_e kind, logic [PIX_W-1:0] pix, logic ken,
                           logic [PIX_W-1:0] kcol);
    int unsigned n;
    if (in_gap_pct != 0 && $urandom_range(99) < in_gap_pct) begin
      in_valid_i = 1'b0;
      n = $urandom_range(18, 1);
      repeat (n) @(negedge clk_i);
    end
    req_type_i = kind;
    src_pixel_i = pix;
    key_enable_i = ken;
    key_color_i = kcol;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    owed_words.push_back(blit_advance(kind, pix, ken, kcol));
    words_sent++;
    @(negedge clk_i);
  endtask

  task automatic push_pixel(logic [PIX_W-1:0] pix);
    send_word(REQ_PIXEL, pix, 1'($urandom), 8'($urandom));
  endtask

  task automatic open_blit(logic ken, logic [PIX_W-1:0] kcol);
    send_word(REQ_START, 8'($urandom), ken, kcol);
  endtask

  // key colored pixels show up often enough to exercise transparency
  function automatic logic [PIX_W-1:0] some_pixel();
    return ($urandom_range(3) == 0) ? key_val : 8'($urandom);
  endfunction

  task automatic drain_blit();
    while (run_busy) begin
      push_pixel(some_pixel());
    end
    in_valid_i = 1'b0;
    while (owed_words.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (4) @(negedge clk_i);
  endtask

  task automatic put_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] value);
    cfg_we_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = value;
    @(negedge clk_i);
  endtask

  task automatic load_region(cfg_t c);
    drain_blit();
    put_reg(CFG_DEST_X, CFG_DATA_W'(c.dest_x));
    put_reg(CFG_DEST_Y, CFG_DATA_W'(c.dest_y));
    put_reg(CFG_REGION_X, CFG_DATA_W'(c.region_x));
    put_reg(CFG_REGION_Y, CFG_DATA_W'(c.region_y));
    put_reg(CFG_REGION_W, CFG_DATA_W'(c.region_w));
    put_reg(CFG_REGION_H, CFG_DATA_W'(c.region_h));
    put_reg(CFG_IMAGE_W, CFG_DATA_W'(c.image_w));
    put_reg(CFG_IMAGE_H, CFG_DATA_W'(c.image_h));
    cfg_we_i = 1'b0;
    region = c;
  endtask

  function automatic cfg_t make_region(int unsigned dx, int unsigned dy, int unsigned rx,
                                       int unsigned ry, int unsigned rw, int unsigned rh,
                                       int unsigned iw, int unsigned ih);
    cfg_t c;
    c.dest_x = DX_W'(dx);
    c.dest_y = DY_W'(dy);
    c.region_x = COL_W'(rx);
    c.region_y = ROW_W'(ry);
    c.region_w = COL_W'(rw);
    c.region_h = ROW_W'(rh);
    c.image_w = COL_W'(iw);
    c.image_h = ROW_W'(ih);
    return c;
  endfunction

  function automatic int unsigned pick_span(int unsigned lo, int unsigned hi);
    int unsigned r;
    r = $urandom_range(9);
    if (r < 2) return lo;
    if (r < 4) return hi;
    return $urandom_range(hi, lo);
  endfunction

  function automatic int unsigned pick_gap();
    case ($urandom_range(2))
      0: return 0;
      1: return 10;
      default: return 40;
    endcase
  endfunction

  task automatic run_blit();
    int unsigned n;
    int unsigned cut;
    open_blit(1'($urandom), 8'($urandom));
    if (run_busy) begin
      n = 32'(region.region_w) * 32'(region.region_h);
      // now and then the blit is cut short and the next start abandons it
      cut = ($urandom_range(9) == 0) ? $urandom_range(n - 1) : n;
      repeat (cut) push_pixel(some_pixel());
    end
    if (!run_busy && $urandom_range(9) == 0) begin
      push_pixel(8'($urandom));
    end
  endtask

  task automatic test_after_reset();
    // default region is empty: start ends at once, a pixel then is unexpected
    open_blit(1'b1, 8'h00);
    push_pixel(8'hFF);
  endtask

  task automatic test_far_corner();
    load_region(make_region(319, 199, 1023, 255, 2, 2, 1023, 255));
    open_blit(1'b1, 8'hFF);
    push_pixel(8'hFF);
    push_pixel(8'h00);
    push_pixel(8'hAA);
    push_pixel(8'h55);
    push_pixel(8'h3C);
  endtask

  task automatic test_walk_and_restart();
    // one-pixel-wide image: the row walk runs back into the header and wraps
    load_region(make_region(0, 0, 0, 0, 3, 2, 1, 1));
    open_blit(1'b0, 8'h5A);
    push_pixel(8'h5A);
    push_pixel(8'h11);
    open_blit(1'b1, 8'h00);
    push_pixel(8'h00);
    push_pixel(8'hFF);
    push_pixel(8'h00);
    push_pixel(8'h80);
    push_pixel(8'h01);
    push_pixel(8'h00);
  endtask

  task automatic test_zero_size();
    load_region(make_region(100, 50, 7, 3, 0, 5, 40, 20));
    open_blit(1'b1, 8'h42);
    load_region(make_region(100, 50, 7, 3, 5, 0, 40, 20));
    open_blit(1'b0, 8'hBD);
    push_pixel(8'h42);
  endtask

  task automatic test_largest_region();
    // tallest region, one column at the far right edge
    load_region(make_region(319, 0, 1023, 0, 1, 255, 1023, 255));
    run_blit();
  endtask

  task automatic test_random_blits();
    int unsigned first;
    cfg_t c;
    first = words_sent;
    while (words_sent - first < 200) begin
      c = make_region(pick_span(0, 319), pick_span(0, 199), pick_span(0, 1023),
                      pick_span(0, 255), 0, 0, pick_span(1, 1023), pick_span(1, 255));
      c.region_w = ($urandom_range(9) == 0) ? '0 : COL_W'($urandom_range(12, 1));
      c.region_h = ($urandom_range(9) == 0) ? '0 : ROW_W'($urandom_range(6, 1));
      load_region(c);
      in_gap_pct = pick_gap();
      out_gap_pct = pick_gap();
      repeat ($urandom_range(4, 1)) run_blit();
    end
  endtask

  task automatic test_quiet_tail();
    in_gap_pct = 0;
    out_gap_pct = 0;
    load_region(make_region(12, 198, 30, 10, 9, 4, 64, 40));
    repeat (2) run_blit();
    load_region(make_region(300, 0, 0, 39, 7, 5, 7, 40));
    repeat (2) run_blit();
  endtask

  task automatic finish_run();
    drain_blit();
    repeat (10) @(negedge clk_i);
    if (bad_words == 0 && owed_words.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  endtask

  initial begin
    region = make_region(0, 0, 0, 0, 0, 0, 1, 1);
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_after_reset();
    test_far_corner();
    test_walk_and_restart();
    test_zero_size();
    test_largest_region();
    test_random_blits();
    test_quiet_tail();
    finish_run();
  end

endmodule

`default_nettype wire
